FILE: design/npp_pkg.sv
// Shared types and constants for the nearest point on polyline block.
package npp_pkg;

	localparam int CW = 32;
	localparam int EW = 33;
	localparam int PW = 66;
	localparam int NW = 98;
	localparam int DW = 64;
	localparam int LW = 63;

	localparam logic [LW-1:0] START_RESET = 63'd17179869184000000;

	typedef enum logic [1:0] {
		CFG_QUERY_X     = 2'd0,
		CFG_QUERY_Y     = 2'd1,
		CFG_START_LIMIT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CW-1:0] x1;
		logic [CW-1:0] y1;
		logic [CW-1:0] x2;
		logic [CW-1:0] y2;
	} seg_req_t;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [DW-1:0] sqd;
	} seg_res_t;

endpackage

FILE: design/npp_mul.sv
// Registered 33 by 33 unsigned multiplier shared by the segment sequencer.
module npp_mul (
	input  logic                  clk,
	input  logic [npp_pkg::EW-1:0] a,
	input  logic [npp_pkg::EW-1:0] b,
	output logic [npp_pkg::PW-1:0] p_q
);
	import npp_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= PW'(a) * PW'(b);
	end

endmodule

FILE: design/npp_div.sv
// Radix-2 restoring divider with round-half-up, 33-bit quotient.
module npp_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [npp_pkg::NW-1:0] num,
	input  logic [npp_pkg::PW-1:0] den,
	output logic                  done,
	output logic [npp_pkg::EW-1:0] quo
);
	import npp_pkg::*;

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_RUN  = 3'b010,
		D_RND  = 3'b100
	} div_state_t;

	div_state_t      state_q;
	logic [PW-1:0]   rem_q;
	logic [EW-1:0]   low_q;
	logic [EW-1:0]   quo_q;
	logic [5:0]      cnt_q;
	logic            done_q;
	logic [PW:0]     trial;
	logic [PW:0]     twice;
	logic            ge;

	assign trial = {rem_q, low_q[EW-1]};
	assign ge    = trial >= {1'b0, den};
	assign twice = {rem_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(EW - 1)) begin
						state_q <= D_RND;
					end
				end
				D_RND: begin
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					rem_q <= {1'b0, num[NW-1:EW]};
					low_q <= num[EW-1:0];
					quo_q <= '0;
				end
			end
			D_RUN: begin
				rem_q <= ge ? PW'(trial - {1'b0, den}) : trial[PW-1:0];
				low_q <= {low_q[EW-2:0], 1'b0};
				quo_q <= {quo_q[EW-2:0], ge};
			end
			D_RND: begin
				if (twice >= {1'b0, den}) begin
					quo_q <= quo_q + EW'(1);
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: design/npp_seg.sv
// Segment sequencer: projection, endpoint fallback and squared distance on shared units.
module npp_seg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  npp_pkg::seg_req_t     req,
	input  logic [npp_pkg::CW-1:0] qx,
	input  logic [npp_pkg::CW-1:0] qy,
	output logic                  done,
	output npp_pkg::seg_res_t     res
);
	import npp_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_ZCHK = 12'b000000000010,
		S_DEN0 = 12'b000000000100,
		S_DEN1 = 12'b000000001000,
		S_TX   = 12'b000000010000,
		S_TY   = 12'b000000100000,
		S_DEC  = 12'b000001000000,
		S_P0   = 12'b000010000000,
		S_P1   = 12'b000100000000,
		S_P2   = 12'b001000000000,
		S_DIV  = 12'b010000000000,
		S_Q    = 12'b100000000000
	} seg_state_t;

	seg_state_t      state_q;
	logic [1:0]      qph_q;
	logic [CW-1:0]   x1_q, y1_q, x2_q, y2_q, px_q, py_q;
	logic [PW-1:0]   acc_q, den_q, n_q;
	logic [67:0]     s_q;
	logic [EW-1:0]   ox_q;
	logic            axis_q, ep_q, second_q, done_q;
	logic [DW-1:0]   d1_q;
	seg_res_t        res_q;

	logic [EW-1:0]   dx, dy, ux, uy, ax, ay, mux, muy, ex, ey, mex, mey, dsel;
	logic [EW-1:0]   mul_a, mul_b, quo;
	logic [PW-1:0]   prod;
	logic [67:0]     s_sum;
	logic            on_seg, sat, div_start, div_done;
	logic [DW:0]     sum;
	logic [DW-1:0]   sq_now;
	logic [NW-1:0]   num;
	logic [EW-1:0]   fx, fy;

	function automatic logic [EW-1:0] mag(input logic [EW-1:0] v);
		mag = v[EW-1] ? EW'(~v + EW'(1)) : v;
	endfunction

	assign dx  = {x2_q[CW-1], x2_q} - {x1_q[CW-1], x1_q};
	assign dy  = {y2_q[CW-1], y2_q} - {y1_q[CW-1], y1_q};
	assign ux  = {qx[CW-1], qx} - {x1_q[CW-1], x1_q};
	assign uy  = {qy[CW-1], qy} - {y1_q[CW-1], y1_q};
	assign ex  = {px_q[CW-1], px_q} - {qx[CW-1], qx};
	assign ey  = {py_q[CW-1], py_q} - {qy[CW-1], qy};
	assign ax  = mag(dx);
	assign ay  = mag(dy);
	assign mux = mag(ux);
	assign muy = mag(uy);
	assign mex = mag(ex);
	assign mey = mag(ey);
	assign dsel = axis_q ? ay : ax;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_DEN0: begin mul_a = ax; mul_b = ax; end
			S_DEN1: begin mul_a = ay; mul_b = ay; end
			S_TX: begin mul_a = mux; mul_b = ax; end
			S_TY: begin mul_a = muy; mul_b = ay; end
			S_P0: begin mul_a = dsel; mul_b = n_q[EW-1:0]; end
			S_P1: begin mul_a = dsel; mul_b = n_q[PW-1:EW]; end
			S_Q: begin
				if (qph_q == 2'd0) begin
					mul_a = mex;
					mul_b = mex;
				end else begin
					mul_a = mey;
					mul_b = mey;
				end
			end
			default: ;
		endcase
	end

	npp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	assign num       = NW'({prod, 33'b0} + {33'b0, acc_q});
	assign div_start = state_q == S_P2;

	npp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign s_sum  = (uy[EW-1] != dy[EW-1]) ? s_q - {2'b0, prod} : s_q + {2'b0, prod};
	assign on_seg = !s_sum[67] && (s_sum[66:0] <= {1'b0, den_q});

	assign fx = dx[EW-1] ? {x1_q[CW-1], x1_q} - ox_q : {x1_q[CW-1], x1_q} + ox_q;
	assign fy = dy[EW-1] ? {y1_q[CW-1], y1_q} - quo : {y1_q[CW-1], y1_q} + quo;

	assign sat    = mex[EW-1] | mey[EW-1] | sum[DW];
	assign sum    = {1'b0, acc_q[DW-1:0]} + {1'b0, prod[DW-1:0]};
	assign sq_now = sat ? '1 : sum[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			qph_q    <= '0;
			axis_q   <= 1'b0;
			ep_q     <= 1'b0;
			second_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_ZCHK;
					end
				end
				S_ZCHK: begin
					if (ax == '0 && ay == '0) begin
						ep_q    <= 1'b0;
						qph_q   <= '0;
						state_q <= S_Q;
					end else begin
						state_q <= S_DEN0;
					end
				end
				S_DEN0: state_q <= S_DEN1;
				S_DEN1: state_q <= S_TX;
				S_TX:   state_q <= S_TY;
				S_TY:   state_q <= S_DEC;
				S_DEC: begin
					axis_q <= 1'b0;
					if (on_seg) begin
						state_q <= S_P0;
					end else begin
						ep_q     <= 1'b1;
						second_q <= 1'b0;
						qph_q    <= '0;
						state_q  <= S_Q;
					end
				end
				S_P0: state_q <= S_P1;
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						if (!axis_q) begin
							axis_q  <= 1'b1;
							state_q <= S_P0;
						end else begin
							ep_q    <= 1'b0;
							qph_q   <= '0;
							state_q <= S_Q;
						end
					end
				end
				S_Q: begin
					if (qph_q != 2'd2) begin
						qph_q <= qph_q + 2'd1;
					end else if (ep_q && !second_q) begin
						second_q <= 1'b1;
						qph_q    <= '0;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					x1_q <= req.x1;
					y1_q <= req.y1;
					x2_q <= req.x2;
					y2_q <= req.y2;
				end
			end
			S_ZCHK: begin
				px_q <= x1_q;
				py_q <= y1_q;
			end
			S_DEN1: acc_q <= prod;
			S_TX: den_q <= acc_q + prod;
			S_TY: s_q <= (ux[EW-1] != dx[EW-1]) ? 68'(0) - {2'b0, prod} : {2'b0, prod};
			S_DEC: begin
				n_q  <= s_sum[PW-1:0];
				px_q <= x1_q;
				py_q <= y1_q;
			end
			S_P1: acc_q <= prod;
			S_DIV: begin
				if (div_done) begin
					if (!axis_q) begin
						ox_q <= quo;
					end else begin
						px_q <= fx[CW-1:0];
						py_q <= fy[CW-1:0];
					end
				end
			end
			S_Q: begin
				if (qph_q == 2'd1) begin
					acc_q <= prod;
				end else if (qph_q == 2'd2) begin
					if (ep_q && !second_q) begin
						d1_q <= sq_now;
						px_q <= x2_q;
						py_q <= y2_q;
					end else if (ep_q && d1_q <= sq_now) begin
						res_q <= '{x: x1_q, y: y1_q, sqd: d1_q};
					end else begin
						res_q <= '{x: px_q, y: py_q, sqd: sq_now};
					end
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

FILE: design/nearest_point_on_polyline.sv
// Top level: stream ports, configuration registers, best-point tracking and result register.
// A segment whose foot falls inside it is held up by the shared radix-2 divider
// (33 steps plus rounding per coordinate, two divisions per segment); one whose foot falls
// outside it and a zero-length one skip the divider. s_tready is low while a segment runs.
// A last vertex then loads the result register, and waits while an older result stalls.
// arst_n clears the query to (0,0), start_limit and best distance to 4000000.0, the previous
// vertex and best point to zero, and drops m_tvalid.
module nearest_point_on_polyline (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [63:0]            s_tdata,  // vertex_x[31:0], vertex_y[63:32]
	input  logic                   s_tuser,  // first_vertex
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [63:0]            m_tdata,  // best_x[31:0], best_y[63:32]
	output logic                   m_tuser,  // found
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [npp_pkg::LW-1:0] cfg_data
);
	import npp_pkg::*;

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_SEG  = 3'b010,
		T_EMIT = 3'b100
	} top_state_t;

	top_state_t     state_q;
	logic [CW-1:0]  qx_q, qy_q, prev_x_q, prev_y_q, best_px_q, best_py_q;
	logic [LW-1:0]  lim_q;
	logic [DW-1:0]  best_dist_q;
	logic           have_q, last_q, m_tvalid_q, found_q;
	logic [CW-1:0]  out_x_q, out_y_q;
	logic           in_xfer, seg_start, seg_done, emit;
	seg_req_t       req;
	seg_res_t       res;

	assign s_tready  = state_q == T_IDLE;
	assign in_xfer   = s_tvalid && s_tready;
	assign seg_start = in_xfer && !s_tuser;
	assign emit      = state_q == T_EMIT && (!m_tvalid_q || m_tready);
	assign req       = '{x1: prev_x_q, y1: prev_y_q, x2: s_tdata[31:0], y2: s_tdata[63:32]};

	npp_seg u_seg (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seg_start),
		.req    (req),
		.qx     (qx_q),
		.qy     (qy_q),
		.done   (seg_done),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			qx_q        <= '0;
			qy_q        <= '0;
			lim_q       <= START_RESET;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			best_dist_q <= {1'b0, START_RESET};
			best_px_q   <= '0;
			best_py_q   <= '0;
			have_q      <= 1'b0;
			last_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_QUERY_X:     qx_q  <= cfg_data[CW-1:0];
					CFG_QUERY_Y:     qy_q  <= cfg_data[CW-1:0];
					CFG_START_LIMIT: lim_q <= cfg_data;
					default: ;
				endcase
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (in_xfer) begin
						prev_x_q <= s_tdata[31:0];
						prev_y_q <= s_tdata[63:32];
						last_q   <= s_tlast;
						if (s_tuser) begin
							best_dist_q <= {1'b0, lim_q};
							best_px_q   <= '0;
							best_py_q   <= '0;
							have_q      <= 1'b0;
							state_q     <= s_tlast ? T_EMIT : T_IDLE;
						end else begin
							state_q <= T_SEG;
						end
					end
				end
				T_SEG: begin
					if (seg_done) begin
						if (res.sqd < best_dist_q) begin
							best_dist_q <= res.sqd;
							best_px_q   <= res.x;
							best_py_q   <= res.y;
							have_q      <= 1'b1;
						end
						state_q <= last_q ? T_EMIT : T_IDLE;
					end
				end
				T_EMIT: begin
					if (emit) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_x_q <= have_q ? best_px_q : '0;
			out_y_q <= have_q ? best_py_q : '0;
			found_q <= have_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_y_q, out_x_q};
	assign m_tuser  = found_q;

endmodule

FILE: tb/tb.sv
// Testbench for nearest_point_on_polyline: random polylines checked against a built-in predictor.
module tb;
	import npp_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam logic [LW-1:0] LIMIT_MAX = '1;
	localparam int WATCHDOG = 40000;

	typedef struct {
		bit [31:0] x;
		bit [31:0] y;
		bit        found;
	} best_point_t;

	class nearest_point_board;
		longint qx, qy, px, py, bx, by;
		bit [63:0] best_dist;
		bit [62:0] limit;
		bit have;
		best_point_t pending[$];
		int errors;

		function void clear();
			qx = 0; qy = 0; px = 0; py = 0; bx = 0; by = 0;
			limit = START_RESET;
			best_dist = {1'b0, START_RESET};
			have = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [LW-1:0] v);
			if (idx == CFG_QUERY_X) qx = $signed(v[31:0]);
			else if (idx == CFG_QUERY_Y) qy = $signed(v[31:0]);
			else if (idx == CFG_START_LIMIT) limit = v;
		endfunction

		function bit [63:0] sq_dist(longint ax, longint ay, longint cx, longint cy);
			longint ex, ey;
			bit [63:0] mx, my;
			bit [64:0] s;
			ex = ax - cx;
			ey = ay - cy;
			mx = ex < 0 ? -ex : ex;
			my = ey < 0 ? -ey : ey;
			if (mx[63:32] != 0 || my[63:32] != 0) return '1;
			s = {1'b0, mx * mx} + {1'b0, my * my};
			return s[64] ? '1 : s[63:0];
		endfunction

		function bit [63:0] scale(bit [127:0] d, bit [127:0] n, bit [127:0] den);
			bit [127:0] p, q, r;
			p = d * n;
			q = p / den;
			r = p % den;
			if ({r, 1'b0} >= {1'b0, den}) q = q + 1;
			return q[63:0];
		endfunction

		function void offer(longint x, longint y, bit [63:0] d);
			if (d < best_dist) begin
				best_dist = d; bx = x; by = y; have = 1;
			end
		endfunction

		function void segment(longint x1, longint y1, longint x2, longint y2);
			longint dx, dy, ux, uy, fx, fy;
			bit [127:0] ax, ay, den, tx, ty, pos, neg, n;
			bit [63:0] ox, oy, d1, d2;
			dx = x2 - x1; dy = y2 - y1;
			ux = qx - x1; uy = qy - y1;
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			if (ax == 0 && ay == 0) begin
				offer(x1, y1, sq_dist(x1, y1, qx, qy));
				return;
			end
			den = ax * ax + ay * ay;
			tx = (ux < 0 ? 128'(-ux) : 128'(ux)) * ax;
			ty = (uy < 0 ? 128'(-uy) : 128'(uy)) * ay;
			pos = 0; neg = 0;
			if ((ux < 0) != (dx < 0)) neg += tx; else pos += tx;
			if ((uy < 0) != (dy < 0)) neg += ty; else pos += ty;
			if (pos >= neg) begin
				n = pos - neg;
				if (den >= n) begin
					ox = scale(ax, n, den);
					oy = scale(ay, n, den);
					fx = dx < 0 ? x1 - longint'(ox) : x1 + longint'(ox);
					fy = dy < 0 ? y1 - longint'(oy) : y1 + longint'(oy);
					offer(fx, fy, sq_dist(fx, fy, qx, qy));
					return;
				end
			end
			d1 = sq_dist(x1, y1, qx, qy);
			d2 = sq_dist(x2, y2, qx, qy);
			if (d1 <= d2) offer(x1, y1, d1);
			else offer(x2, y2, d2);
		endfunction

		function void note_vertex(bit [31:0] vx, bit [31:0] vy, bit first, bit last);
			best_point_t e;
			if (first) begin
				best_dist = {1'b0, limit}; bx = 0; by = 0; have = 0;
			end else begin
				segment(px, py, longint'($signed(vx)), longint'($signed(vy)));
			end
			px = $signed(vx);
			py = $signed(vy);
			if (last) begin
				e.x = have ? bx[31:0] : 32'd0;
				e.y = have ? by[31:0] : 32'd0;
				e.found = have;
				pending.push_back(e);
			end
		endfunction

		function void check_result(bit [31:0] x, bit [31:0] y, bit found);
			best_point_t e;
			if (pending.size() == 0) begin
				$error("unexpected result x=%h y=%h found=%0d", x, y, found);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (x !== e.x) begin
				$error("best_x expected %h actual %h", e.x, x); errors++;
			end
			if (y !== e.y) begin
				$error("best_y expected %h actual %h", e.y, y); errors++;
			end
			if (found !== e.found) begin
				$error("found expected %0d actual %0d", e.found, found); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser, s_tlast;
	logic [63:0] s_tdata;
	logic m_tvalid, m_tready, m_tuser;
	logic [63:0] m_tdata;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [LW-1:0] cfg_data;

	nearest_point_board board;
	int src_idle, snk_idle, quiet;
	bit [31:0] lx, ly;

	nearest_point_on_polyline i_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_idle);
		if (m_tvalid && m_tready) board.check_result(m_tdata[31:0], m_tdata[63:32], m_tuser);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send(bit [31:0] vx, bit [31:0] vy, bit first, bit last);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {vy, vx};
		s_tuser <= first;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		board.note_vertex(vx, vy, first, last);
		lx = vx; ly = vy;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [LW-1:0] v);
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		board.set_reg(idx, v);
	endtask

	function automatic bit [31:0] coord(longint q, bit near);
		int sh;
		sh = $urandom_range(22, 4);
		if (!near) return $urandom;
		return 32'(q + longint'($urandom_range((1 << sh) - 1)) - (longint'(1) << (sh - 1)));
	endfunction

	task automatic polyline(int n, bit near);
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(9) == 0) send(lx, ly, 0, i == n - 1);
			else send(coord(board.qx, near), coord(board.qy, near), i == 0, i == n - 1);
		end
	endtask

	initial begin
		logic [LW-1:0] lim;
		board = new();
		board.clear();
		arst_n = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0; s_tlast = 0;
		m_tready = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
		src_idle = 20; snk_idle = 87; quiet = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// segments from the reset origin before any first vertex
		send(32'h0002_0000, 32'h0001_0000, 0, 0);
		send(32'hFFFE_0000, 32'h0001_0000, 0, 1);
		send(32'h1234_5678, 32'h0000_0000, 1, 1);
		send(32'h7FFF_FFFF, 32'h8000_0000, 1, 0);
		send(32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
		send(32'h8000_0000, 32'h7FFF_FFFF, 0, 1);
		send(32'h0001_0000, 32'h0001_0000, 1, 0);
		send(32'h0001_0000, 32'h0001_0000, 0, 0);
		send(32'h0003_0000, 32'h0001_0000, 0, 0);
		send(32'hFFFF_0000, 32'hFFFF_0000, 0, 0);
		send(32'h0001_0000, 32'hFFFF_0000, 0, 1);
		write_reg(CFG_QUERY_X, LW'(32'h0000_8000));
		write_reg(CFG_QUERY_Y, LW'(32'hFFFF_8000));
		write_reg(CFG_UNUSED, '1);
		send(32'h0000_0000, 32'h0000_0000, 1, 0);
		send(32'h0001_0000, 32'h0000_0000, 0, 0);
		send(32'h0001_0000, 32'hFFFF_0000, 0, 1);
		write_reg(CFG_START_LIMIT, '0);
		send(32'h0000_8000, 32'hFFFF_8000, 1, 0);
		send(32'h0000_8000, 32'hFFFF_8000, 0, 1);
		write_reg(CFG_START_LIMIT, LIMIT_MAX);
		send(32'h8000_0000, 32'h8000_0000, 1, 0);
		send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: begin src_idle = 20; snk_idle = 87; end
				1: begin src_idle = 87; snk_idle = 20; end
				default: begin src_idle = 0; snk_idle = 0; end
			endcase
			case (ph)
				0: lim = START_RESET;
				1: lim = '0;
				2: lim = LIMIT_MAX;
				3: lim = 63'h4_0000_0000;
				default: lim = LW'({$urandom, $urandom});
			endcase
			write_reg(CFG_QUERY_X,
				LW'(ph == 2 ? 32'h8000_0000 : ph == 3 ? 32'h7FFF_FFFF : $urandom));
			write_reg(CFG_QUERY_Y,
				LW'(ph == 2 ? 32'h7FFF_FFFF : ph == 3 ? 32'h8000_0000 : $urandom));
			write_reg(CFG_START_LIMIT, lim);
			for (int k = 0; k < 16; k++) begin
				if ($urandom_range(9) == 0) begin
					repeat ($urandom_range(6, 1))
						send($urandom, $urandom, $urandom_range(3) == 0, $urandom_range(3) == 0);
				end else begin
					polyline($urandom_range(9, 1), $urandom_range(3) != 0);
				end
			end
		end

		s_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule

FILE: nearest_point_on_polyline.f
design/npp_pkg.sv
design/npp_mul.sv
design/npp_div.sv
design/npp_seg.sv
design/nearest_point_on_polyline.sv
tb/tb.sv
